// ===== hdl/efr_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the escaped frame receiver.
// No dependencies; efr_ctrl, efr_dp and the top level import this package.
package efr_pkg;

   localparam int NUM_LINKS    = 2;
   localparam int PAYLOAD_MAX  = 256;
   localparam int HEADER_BYTES = 8;
   localparam int CRC_BYTES    = 4;
   localparam int FRAME_BYTES  = HEADER_BYTES + PAYLOAD_MAX + CRC_BYTES;
   // the link field is one bit wide, so two slots of state cover every code
   localparam int LINK_SLOTS   = 2;
   localparam int STORE_DEPTH  = LINK_SLOTS * FRAME_BYTES;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int FILL_W       = $clog2(FRAME_BYTES + 1);

   localparam logic [7:0] MARK_A   = 8'haa;
   localparam logic [7:0] MARK_B   = 8'h55;
   localparam logic [7:0] ESC_BYTE = 8'ha5;

   // escape tracker phases
   localparam logic [2:0] ESC_NONE    = 3'd0;
   localparam logic [2:0] ESC_MARK    = 3'd1;
   localparam logic [2:0] ESC_PEND    = 3'd2;
   localparam logic [2:0] ESC_DONE    = 3'd3;
   localparam logic [2:0] ESC_PEND2   = 3'd4;

   localparam logic [1:0] KIND_LOCAL = 2'd0;
   localparam logic [1:0] KIND_FWD   = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] CSR_NODE_ADDR     = 2'd0;
   localparam logic [1:0] CSR_RESERVED_ADDR = 2'd1;

   localparam logic [31:0] CRC_INIT = 32'hffffffff;
   localparam logic [31:0] CRC_POLY = 32'hedb88320;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CRC,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;      // capture an input item
      logic step;      // apply a link byte to the decoder
      logic rd_issue;  // start a payload read
      logic rd_done;   // payload read data is back
      logic crc_run;   // one CRC sweep step
      logic fin;       // settle the frame after the sweep
      logic emit;      // load the output register
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic link_ok;
      logic check;     // frame complete, CRC sweep needed
      logic crc_last;  // sweep handles its final byte this cycle
      logic frame_ok;
      logic out_free;
   } status_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/efr_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module efr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

// ===== hdl/efr_ctrl.sv =====
// Controller state machine of the escaped frame receiver.
// Depends on efr_pkg; drives commands to efr_dp and reads its status.
module efr_ctrl import efr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!st.link_ok) state_in = ST_IDLE;
            else if (st.mode) state_in = ST_READ;
            else if (st.check) state_in = ST_CRC;
            else state_in = ST_IDLE;
         end
         ST_READ:   state_in = ST_EMIT;
         ST_CRC: begin
            if (st.crc_last) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = st.frame_ok ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (st.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ST_DECODE: begin
            cmd.step     = st.link_ok && !st.mode;
            cmd.rd_issue = st.link_ok && st.mode;
         end
         ST_READ:   cmd.rd_done = 1'b1;
         ST_CRC:    cmd.crc_run = 1'b1;
         ST_FINISH: cmd.fin     = 1'b1;
         ST_EMIT:   cmd.emit    = st.out_free;
         default:   cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/efr_dp.sv =====
// Datapath: per-link decoder state, header registers, CRC sweep and output register.
// Depends on efr_pkg and efr_ram; sequenced by efr_ctrl.
module efr_dp import efr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic        req_mode,
   input  logic        req_link,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_index,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic        rsp_link_out,
   output logic [7:0]  rsp_source_id,
   output logic [7:0]  rsp_dest_id,
   output logic [15:0] rsp_msg_id,
   output logic [8:0]  rsp_body_len,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_error_count,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // configuration
   logic [7:0] node_addr_ff, reserved_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff     <= 8'd1;
         reserved_addr_ff <= 8'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NODE_ADDR:     node_addr_ff     <= csr_wdata;
            CSR_RESERVED_ADDR: reserved_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured item
   logic       mode_ff, link_ff;
   logic [7:0] byte_ff, index_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff  <= req_mode;
         link_ff  <= req_link;
         byte_ff  <= req_rx_byte;
         index_ff <= req_read_index;
      end
   end

   // per-link state
   logic [FILL_W-1:0] fill_ff  [LINK_SLOTS];
   logic [2:0]        esc_ff   [LINK_SLOTS];
   logic [FILL_W-1:0] flen_ff  [LINK_SLOTS];
   logic [15:0]       tally_ff [LINK_SLOTS];
   logic [7:0]        hdr_ff   [LINK_SLOTS][HEADER_BYTES];

   logic [FILL_W-1:0] f, fw, fw1, f_n, fl, fl_n;
   logic [2:0]        e, ew, e_n;
   logic [15:0]       plen_new;
   logic              wr, chk, err, done, restart;

   assign f       = fill_ff[link_ff];
   assign e       = esc_ff[link_ff];
   assign fl      = flen_ff[link_ff];
   assign restart = (byte_ff == MARK_A);

   // decoder step for one link byte
   always_comb begin
      f_n = f; e_n = e; fl_n = fl;
      fw = f; fw1 = f; ew = e;
      wr = 1'b0; chk = 1'b0; err = 1'b0; done = 1'b0;
      plen_new = {hdr_ff[link_ff][6], hdr_ff[link_ff][7]};
      if (f < FILL_W'(2)) begin
         // hunting for the start mark
         fl_n = '0;
         done = 1'b1;
         if (f == '0) begin
            if (byte_ff == MARK_A) f_n = FILL_W'(1);
         end else if (byte_ff == MARK_B) begin
            f_n = FILL_W'(2);
            e_n = ESC_NONE;
         end else begin
            f_n = '0;
         end
      end else begin
         case (e)
            ESC_NONE: begin
               if (byte_ff == MARK_A) ew = ESC_MARK;
            end
            ESC_MARK: begin
               if (byte_ff == ESC_BYTE) ew = ESC_PEND;
               else if (byte_ff == MARK_A) ew = ESC_MARK;
               else if (byte_ff == MARK_B) begin
                  // start mark inside a frame
                  f_n = FILL_W'(2); e_n = ESC_NONE; fl_n = '0;
                  err = 1'b1; done = 1'b1;
               end else ew = ESC_NONE;
            end
            ESC_PEND, ESC_PEND2: begin
               if (byte_ff == ESC_BYTE) begin
                  ew = ESC_DONE; fw = f - FILL_W'(1);
               end else if (e == ESC_PEND && byte_ff == MARK_B) begin
                  ew = ESC_NONE; fw = f - FILL_W'(1);
               end else begin
                  // broken escape
                  f_n = FILL_W'(restart); fl_n = '0;
                  err = 1'b1; done = 1'b1;
               end
            end
            ESC_DONE: begin
               if (byte_ff == ESC_BYTE) ew = ESC_PEND2;
               else if (byte_ff == MARK_A) ew = ESC_MARK;
               else ew = ESC_NONE;
            end
            default: ew = ESC_NONE;
         endcase
         if (!done) begin
            e_n = ew;
            if (fw >= FILL_W'(FRAME_BYTES)) begin
               f_n = '0; fl_n = '0; done = 1'b1;
            end else begin
               wr  = 1'b1;
               fw1 = fw + FILL_W'(1);
               f_n = fw1;
               plen_new = {(fw == FILL_W'(6)) ? byte_ff : hdr_ff[link_ff][6],
                           (fw == FILL_W'(7)) ? byte_ff : hdr_ff[link_ff][7]};
               if (fl == '0 && ((fw1 >= FILL_W'(HEADER_BYTES) && ew != ESC_PEND &&
                   ew != ESC_PEND2) || fw1 > FILL_W'(HEADER_BYTES))) begin
                  if (plen_new > 16'(PAYLOAD_MAX)) begin
                     f_n = FILL_W'(restart); fl_n = '0;
                     err = 1'b1; done = 1'b1;
                  end else begin
                     fl_n = FILL_W'(HEADER_BYTES + CRC_BYTES) + FILL_W'(plen_new);
                  end
               end
               if (!done && fl_n != '0 && fl_n <= fw1 && ew != ESC_PEND &&
                   ew != ESC_PEND2) begin
                  chk = 1'b1;
               end
            end
         end
      end
   end

   // CRC sweep over the stored frame
   logic [FILL_W-1:0] crc_addr_ff, crc_pos_ff, fl4;
   logic              crc_dv_ff, crc_bad_ff;
   logic [31:0]       crc_ff, crc_fin;
   logic [7:0]        q, sweep_byte, expect_byte;
   logic [1:0]        k;
   logic              frame_ok;

   assign fl4     = fl - FILL_W'(CRC_BYTES);
   assign crc_fin = ~crc_ff;
   assign k       = 2'(crc_pos_ff - fl4);

   always_comb begin
      if (crc_pos_ff == '0) sweep_byte = MARK_A;
      else if (crc_pos_ff == FILL_W'(1)) sweep_byte = MARK_B;
      else sweep_byte = q;
      case (k)
         2'd0:    expect_byte = crc_fin[31:24];
         2'd1:    expect_byte = crc_fin[23:16];
         2'd2:    expect_byte = crc_fin[15:8];
         default: expect_byte = crc_fin[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.step && chk) begin
         crc_addr_ff <= '0;
         crc_dv_ff   <= 1'b0;
         crc_ff      <= CRC_INIT;
         crc_bad_ff  <= 1'b0;
      end else if (cmd.crc_run) begin
         crc_addr_ff <= crc_addr_ff + FILL_W'(1);
         crc_pos_ff  <= crc_addr_ff;
         crc_dv_ff   <= 1'b1;
         if (crc_dv_ff) begin
            if (crc_pos_ff < fl4) crc_ff <= crc32_byte(crc_ff, sweep_byte);
            else if (sweep_byte != expect_byte) crc_bad_ff <= 1'b1;
         end
      end
   end

   assign frame_ok = !crc_bad_ff && (hdr_ff[link_ff][2] != reserved_addr_ff);

   // store access
   logic [ADDR_W-1:0] base, ram_addr;
   logic [7:0]        rd_val;
   logic [15:0]       plen_cur;
   logic              rd_ok;

   assign base = link_ff ? ADDR_W'(FRAME_BYTES) : '0;

   always_comb begin
      if (cmd.step) ram_addr = base + ADDR_W'(fw);
      else if (cmd.rd_issue) ram_addr = base + ADDR_W'(HEADER_BYTES) + ADDR_W'(index_ff);
      else ram_addr = base + ADDR_W'(crc_addr_ff);
   end

   efr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (cmd.step && wr),
      .addr  (ram_addr),
      .wdata (byte_ff),
      .rdata (q)
   );

   assign plen_cur = {hdr_ff[link_ff][6], hdr_ff[link_ff][7]};
   assign rd_ok    = ({8'd0, index_ff} < plen_cur) && (32'(index_ff) < PAYLOAD_MAX);
   assign rd_val   = rd_ok ? q : 8'd0;

   // per-link state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINK_SLOTS; i++) begin
            fill_ff[i]  <= '0;
            esc_ff[i]   <= ESC_NONE;
            flen_ff[i]  <= '0;
            tally_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         fill_ff[link_ff] <= f_n;
         esc_ff[link_ff]  <= e_n;
         flen_ff[link_ff] <= fl_n;
         if (err) tally_ff[link_ff] <= tally_ff[link_ff] + 16'd1;
      end else if (cmd.fin) begin
         fill_ff[link_ff] <= frame_ok ? '0 : FILL_W'(restart);
         flen_ff[link_ff] <= '0;
         if (crc_bad_ff) tally_ff[link_ff] <= tally_ff[link_ff] + 16'd1;
      end
   end

   // header copy of the stored bytes
   always_ff @(posedge clock) begin
      if (cmd.step && wr && fw < FILL_W'(HEADER_BYTES)) begin
         hdr_ff[link_ff][fw[2:0]] <= byte_ff;
      end
   end

   // pending result
   logic [1:0] kind_ff;
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_done) begin
         kind_ff  <= KIND_READ;
         rdata_ff <= rd_val;
      end else if (cmd.fin) begin
         kind_ff  <= (hdr_ff[link_ff][3] == node_addr_ff) ? KIND_LOCAL : KIND_FWD;
         rdata_ff <= 8'd0;
      end
   end

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic        rsp_link_out_ff;
   logic [7:0]  rsp_source_id_ff, rsp_dest_id_ff;
   logic [15:0] rsp_msg_id_ff;
   logic [8:0]  rsp_body_len_ff;
   logic [7:0]  rsp_read_data_ff;
   logic [15:0] rsp_error_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff        <= kind_ff;
         rsp_link_out_ff    <= link_ff;
         rsp_source_id_ff   <= hdr_ff[link_ff][2];
         rsp_dest_id_ff     <= hdr_ff[link_ff][3];
         rsp_msg_id_ff      <= {hdr_ff[link_ff][4], hdr_ff[link_ff][5]};
         rsp_body_len_ff    <= {hdr_ff[link_ff][6][0], hdr_ff[link_ff][7]};
         rsp_read_data_ff   <= rdata_ff;
         rsp_error_count_ff <= tally_ff[link_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_link_out    = rsp_link_out_ff;
   assign rsp_source_id   = rsp_source_id_ff;
   assign rsp_dest_id     = rsp_dest_id_ff;
   assign rsp_msg_id      = rsp_msg_id_ff;
   assign rsp_body_len    = rsp_body_len_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_error_count = rsp_error_count_ff;

   // status
   always_comb begin
      st          = '0;
      st.mode     = mode_ff;
      st.link_ok  = (32'(link_ff) < NUM_LINKS);
      st.check    = chk;
      st.crc_last = crc_dv_ff && (crc_pos_ff == fl - FILL_W'(1));
      st.frame_ok = frame_ok;
      st.out_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== hdl/escaped_frame_receiver_crc32.sv =====
// Escaped frame receiver with CRC-32 check: top level.
// Depends on efr_pkg, efr_ctrl, efr_dp (which holds the efr_ram frame store).
//
// Usage:
//   req_* carries one item: a raw link byte (mode 0) or a payload read (mode 1).
//   An item is taken when req_valid is high and req_stall low. rsp_* carries
//   results with the same valid/stall rule; csr_* writes the node address
//   (index 0) and the reserved source address (index 1), always ready.
//   A link byte that completes no frame is only decoded. A payload read is
//   decoded, read and loaded into the output register, and the next item
//   is taken after that. The byte that ends a frame starts a CRC sweep over
//   the stored frame, one byte per cycle from the single-port store, over
//   the whole frame (8 + len + 4 bytes), then the frame is decided and its
//   result is loaded into the output register if the frame passes.
//   One item is in work at a time; a finished result sits in the output
//   register while the next item is accepted. If rsp_stall is held, a second
//   result waits inside and req_stall stays high until the register frees.
//   Reset clears all link state and error counts; the frame store is not
//   cleared, and reading a payload before any frame was stored is undefined.
module escaped_frame_receiver_crc32 import efr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_link,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_link_out,
   output logic [7:0]  rsp_source_id,
   output logic [7:0]  rsp_dest_id,
   output logic [15:0] rsp_msg_id,
   output logic [8:0]  rsp_body_len,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_error_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   efr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   efr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_mode        (req_mode),
      .req_link        (req_link),
      .req_rx_byte     (req_rx_byte),
      .req_read_index  (req_read_index),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_link_out    (rsp_link_out),
      .rsp_source_id   (rsp_source_id),
      .rsp_dest_id     (rsp_dest_id),
      .rsp_msg_id      (rsp_msg_id),
      .rsp_body_len    (rsp_body_len),
      .rsp_read_data   (rsp_read_data),
      .rsp_error_count (rsp_error_count),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // a result is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> st.out_free)
      else $error("result loaded over a waiting result");

   // the last sweep byte is always followed by the frame decision
   assert property (@(posedge clock) disable iff (reset)
      (cmd.crc_run && st.crc_last) |=> cmd.fin)
      else $error("CRC sweep ended without a frame decision");

   // no new item while a read or sweep is in work
   assert property (@(posedge clock) disable iff (reset)
      (cmd.crc_run || cmd.rd_done || cmd.fin) |-> req_stall)
      else $error("input taken during frame work");

   // read results carry data only from mode 1
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_READ) |-> rsp_read_data == 8'd0)
      else $error("frame result carries read data");

endmodule
